@@ hdl/u16u32_pkg.sv @@
package u16u32_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_UNPAIRED  = 3'd1,
        STATUS_SURROGATE = 3'd2,
        STATUS_RANGE     = 3'd3,
        STATUS_TRUNCATED = 3'd4
    } status_t;

    // Register indexes on the configuration port
    localparam logic REG_DIRECTION = 1'b0;

    // Direction codes
    localparam logic DIR_16_TO_32 = 1'b0;
    localparam logic DIR_32_TO_16 = 1'b1;

    // Surrogate and code point limits
    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LAST       = 16'hDFFF;
    localparam logic [20:0] CP_OFFSET       = 21'h10000;
    localparam logic [31:0] CP_MAX          = 32'h0010FFFF;
    localparam logic [31:0] BMP_END         = 32'h00010000;

    // One classified unit: bytes to emit, left-aligned, and the index of the last one
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  last_idx;
        status_t     status;
    } job_t;

    // Control from the register block to the front end
    typedef struct packed {
        logic direction;
        logic clear;
    } cfg_t;

endpackage

@@ hdl/u16u32_front.sv @@
module u16u32_front
    import u16u32_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       job_push,
    output job_t       job
);

    logic [31:0] asm_reg, asm_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        hold_reg, hold_next;

    logic [31:0] shifted;
    logic [1:0]  cnt_inc;
    logic [15:0] unit16;
    logic [20:0] cp_pair;
    logic [20:0] v_full;
    logic [19:0] v;
    logic [15:0] w1, w2;
    logic        is_high, is_low;

    assign shifted = {asm_reg[23:0], data_byte};
    assign cnt_inc = cnt_reg + 2'd1;
    assign unit16  = shifted[15:0];
    assign is_high = (unit16 >= SURR_HIGH_FIRST) && (unit16 < SURR_LOW_FIRST);
    assign is_low  = (unit16 >= SURR_LOW_FIRST) && (unit16 <= SURR_LAST);

    // Pair decode and supplementary encode
    assign cp_pair = {1'b0, pend_reg, unit16[9:0]} + CP_OFFSET;
    assign v_full  = shifted[20:0] - CP_OFFSET;
    assign v       = v_full[19:0];
    assign w1      = SURR_HIGH_FIRST | {6'b0, v[19:10]};
    assign w2      = SURR_LOW_FIRST | {6'b0, v[9:0]};

    // Assembly and classification
    always_comb
    begin
        status_t err;
        logic    emit;

        asm_next        = asm_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        hold_next       = hold_reg;
        job_push        = 1'b0;
        job.word        = '0;
        job.last_idx    = 2'd0;
        job.status      = STATUS_OK;
        err             = STATUS_OK;
        emit            = 1'b0;

        if (accept)
        begin
            if (!hold_reg)
            begin
                asm_next = shifted;
                cnt_next = cnt_inc;
                if (cfg.direction == DIR_16_TO_32)
                begin
                    if (cnt_inc == 2'd2)
                    begin
                        cnt_next = 2'd0;
                        asm_next = '0;
                        if (pend_valid_reg)
                        begin
                            if (is_low)
                            begin
                                emit            = 1'b1;
                                job.word        = {11'b0, cp_pair};
                                job.last_idx    = 2'd3;
                                pend_valid_next = 1'b0;
                                pend_next       = '0;
                            end
                            else
                            begin
                                err = STATUS_UNPAIRED;
                            end
                        end
                        else if (is_high)
                        begin
                            pend_next       = unit16[9:0];
                            pend_valid_next = 1'b1;
                        end
                        else if (is_low)
                        begin
                            err = STATUS_UNPAIRED;
                        end
                        else
                        begin
                            emit         = 1'b1;
                            job.word     = {16'b0, unit16};
                            job.last_idx = 2'd3;
                        end
                    end
                end
                else if (cnt_inc == 2'd0)
                begin
                    asm_next = '0;
                    if ((shifted >= {16'b0, SURR_HIGH_FIRST}) &&
                        (shifted <= {16'b0, SURR_LAST}))
                    begin
                        err = STATUS_SURROGATE;
                    end
                    else if (shifted > CP_MAX)
                    begin
                        err = STATUS_RANGE;
                    end
                    else if (shifted < BMP_END)
                    begin
                        emit         = 1'b1;
                        job.word     = {shifted[15:0], 16'b0};
                        job.last_idx = 2'd1;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        job.word     = {w1, w2};
                        job.last_idx = 2'd3;
                    end
                end

                // End of stream part way through a unit or a pair
                if ((err == STATUS_OK) && end_of_stream &&
                    ((cnt_next != 2'd0) || pend_valid_next))
                begin
                    err = STATUS_TRUNCATED;
                end

                // An error replaces anything else with a single flagged transfer
                if (err != STATUS_OK)
                begin
                    job.word     = '0;
                    job.last_idx = 2'd0;
                    job.status   = err;
                    job_push     = 1'b1;
                    hold_next    = 1'b1;
                end
                else
                begin
                    job_push = emit;
                end
            end

            if (end_of_stream)
            begin
                asm_next        = '0;
                cnt_next        = 2'd0;
                pend_next       = '0;
                pend_valid_next = 1'b0;
                hold_next       = 1'b0;
            end
        end

        if (cfg.clear)
        begin
            asm_next        = '0;
            cnt_next        = 2'd0;
            pend_next       = '0;
            pend_valid_next = 1'b0;
            hold_next       = 1'b0;
        end
    end

    // Stream state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg        <= '0;
            cnt_reg        <= 2'd0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            hold_reg       <= 1'b0;
        end
        else
        begin
            asm_reg        <= asm_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            hold_reg       <= hold_next;
        end
    end

endmodule

@@ hdl/u16u32_queue.sv @@
module u16u32_queue
    import u16u32_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ hdl/u16u32_back.sv @@
module u16u32_back
    import u16u32_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       last_of_run
);

    logic        cur_valid_reg, cur_valid_next;
    logic [31:0] cur_word_reg, cur_word_next;
    logic [1:0]  cur_left_reg, cur_left_next;
    status_t     cur_status_reg, cur_status_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    status_t     out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    logic        out_load, cur_free;

    assign out_load = cur_valid_reg && (!out_valid_reg || pop);
    assign cur_free = !cur_valid_reg || (out_load && (cur_left_reg == 2'd0));
    assign q_pop    = cur_free && q_valid;

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign status      = out_status_reg;
    assign last_of_run = out_last_reg;

    // Byte sequencing from the working job into the output register
    always_comb
    begin
        cur_valid_next  = cur_valid_reg;
        cur_word_next   = cur_word_reg;
        cur_left_next   = cur_left_reg;
        cur_status_next = cur_status_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = cur_word_reg[31:24];
            out_status_next = cur_status_reg;
            out_last_next   = (cur_left_reg == 2'd0);
            cur_word_next   = {cur_word_reg[23:0], 8'b0};
            cur_left_next   = cur_left_reg - 2'd1;
        end

        if (cur_free)
        begin
            cur_valid_next = q_valid;
            if (q_valid)
            begin
                cur_word_next   = q_job.word;
                cur_left_next   = q_job.last_idx;
                cur_status_next = q_job.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_word_reg   <= cur_word_next;
        cur_left_reg   <= cur_left_next;
        cur_status_reg <= cur_status_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

@@ hdl/utf16_utf32_byte_transcoder_top.sv @@
// Path: a result byte passes through the job queue, the working job register and the output register.
// Throughput: the back end emits one byte a cycle while pop is asserted; the job queue
// absorbs bursts of QUEUE_DEPTH units.
// Reset: rst_n is asynchronous and active low; it empties the queue and the output
// register, clears all stream state and sets the direction to UTF-16 to UTF-32.
module utf16_utf32_byte_transcoder_top
    import u16u32_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic        last_of_run
);

    logic direction_reg, direction_next;
    logic cfg_write;
    cfg_t cfg;
    logic job_push;
    job_t job;
    logic q_full, q_not_empty, q_pop;
    job_t q_head;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
    assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'b0, direction_reg} : '0;

    always_comb
    begin
        direction_next = direction_reg;
        if (cfg_write)
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_16_TO_32;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign cfg.direction = direction_reg;
    assign cfg.clear     = cfg_write;
    assign full          = q_full;

    u16u32_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .accept        (push && !q_full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .job_push      (job_push),
        .job           (job)
    );

    u16u32_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    u16u32_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_job       (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

    // A flagged result is a lone zero byte
    a_error_single : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != STATUS_OK)) |-> ((out_byte == 8'd0) && last_of_run))
        else $error("flagged result is not a single zero byte");

    // Bytes of one unit follow without a gap
    a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_run) |=> !empty)
        else $error("gap inside a run of result bytes");

    // The front end never pushes into a full queue
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job pushed into full queue");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import u16u32_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 10;
    localparam int SPARE_REG     = 1;
    localparam int MAX_REPORTS   = 10;
    localparam int LONG_HOLD     = 300;

    // One expected output transfer
    typedef struct {
        logic [7:0] data;
        status_t    code;
        logic       ends_run;
    } xfer_t;

    // Predicts the converted byte stream and checks it against the block
    class transcode_scoreboard;
        xfer_t       expected_q[$];
        xfer_t       run_q[$];
        bit          dir;
        logic [31:0] unit_acc;
        logic [1:0]  unit_len;
        logic [9:0]  high_bits;
        bit          high_held;
        bit          dropping;
        int          fails;
        int          checked;
        int          flagged;

        function new();
            dir = DIR_16_TO_32;
            clear_stream();
        endfunction

        function void clear_stream();
            unit_acc  = '0;
            unit_len  = '0;
            high_bits = '0;
            high_held = 1'b0;
            dropping  = 1'b0;
        endfunction

        function void set_direction(bit d);
            dir = d;
            clear_stream();
        endfunction

        function void fail(string msg);
            fails++;
            if (fails <= MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void add_byte(logic [7:0] b, status_t st);
            xfer_t x;
            x.data     = b;
            x.code     = st;
            x.ends_run = 1'b0;
            run_q.push_back(x);
        endfunction

        function void add_word(logic [31:0] w);
            for (int k = 3; k >= 0; k--)
                add_byte(w[8*k +: 8], STATUS_OK);
        endfunction

        // Works out the output transfers caused by one accepted input byte
        function void note_input(logic [7:0] b, bit eos);
            status_t     fault;
            logic [15:0] u16;
            logic [31:0] u32;
            logic [31:0] cp;
            logic [31:0] v;
            fault = STATUS_OK;
            run_q.delete();
            if (dropping)
            begin
                if (eos)
                    clear_stream();
                return;
            end
            unit_acc = {unit_acc[23:0], b};
            unit_len = unit_len + 2'd1;
            if (dir == DIR_16_TO_32)
            begin
                if (unit_len == 2'd2)
                begin
                    u16      = unit_acc[15:0];
                    unit_len = '0;
                    unit_acc = '0;
                    if (high_held)
                    begin
                        if (u16 >= SURR_LOW_FIRST && u16 <= SURR_LAST)
                        begin
                            cp = 32'(CP_OFFSET) + {12'b0, high_bits, 10'b0}
                                 + {22'b0, u16[9:0]};
                            add_word(cp);
                            high_held = 1'b0;
                            high_bits = '0;
                        end
                        else
                            fault = STATUS_UNPAIRED;
                    end
                    else if (u16 >= SURR_HIGH_FIRST && u16 < SURR_LOW_FIRST)
                    begin
                        high_bits = u16[9:0];
                        high_held = 1'b1;
                    end
                    else if (u16 >= SURR_LOW_FIRST && u16 <= SURR_LAST)
                        fault = STATUS_UNPAIRED;
                    else
                        add_word({16'b0, u16});
                end
            end
            else if (unit_len == 2'd0)
            begin
                u32      = unit_acc;
                unit_acc = '0;
                if (u32 >= SURR_HIGH_FIRST && u32 <= SURR_LAST)
                    fault = STATUS_SURROGATE;
                else if (u32 > CP_MAX)
                    fault = STATUS_RANGE;
                else if (u32 < BMP_END)
                begin
                    add_byte(u32[15:8], STATUS_OK);
                    add_byte(u32[7:0], STATUS_OK);
                end
                else
                begin
                    v = u32 - BMP_END;
                    add_word({SURR_HIGH_FIRST | {6'b0, v[19:10]},
                              SURR_LOW_FIRST | {6'b0, v[9:0]}});
                end
            end
            if (fault == STATUS_OK && eos && (unit_len != 2'd0 || high_held))
                fault = STATUS_TRUNCATED;
            if (fault != STATUS_OK)
            begin
                run_q.delete();
                add_byte(8'h00, fault);
                dropping = 1'b1;
            end
            if (eos)
                clear_stream();
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].ends_run = 1'b1;
            foreach (run_q[i])
                expected_q.push_back(run_q[i]);
        endfunction

        // Compares one output transfer with the oldest expectation
        function void check_result(logic [7:0] b, logic [2:0] st, logic tail);
            xfer_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                fail($sformatf("unexpected output byte %02h status %0d last %0b",
                               b, st, tail));
                return;
            end
            want = expected_q.pop_front();
            if (want.code != STATUS_OK)
                flagged++;
            if (b !== want.data || st !== want.code || tail !== want.ends_run)
                fail($sformatf("expected byte %02h status %0d last %0b, got %02h %0d %0b",
                               want.data, want.code, want.ends_run, b, st, tail));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic        last_of_run;

    transcode_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int bytes_in;
    int dir_writes;
    int cycle_count;

    utf16_utf32_byte_transcoder_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .status        (status),
        .last_of_run   (last_of_run)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: random pop, long holds counted down here
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(out_byte, status, last_of_run);
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input bit eos);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push          <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_input(b, eos);
        bytes_in++;
    endtask

    // Low len bytes of w, most significant first
    task automatic send_word(input logic [31:0] w, input int len, input bit eos);
        for (int k = len - 1; k >= 0; k--)
            send_byte(w[8*k +: 8], eos && (k == 0));
    endtask

    // Stop offering and wait until every expected transfer is out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register write; the direction register is read back afterwards
    task automatic set_register(input int idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, 3'(idx * 4), value, rd);
        if (idx == int'(REG_DIRECTION))
        begin
            sb.set_direction(value[0]);
            dir_writes++;
            apb_access(1'b0, 3'(idx * 4), 32'b0, rd);
            if (rd !== {31'b0, value[0]})
                sb.fail($sformatf("direction read back %08h, expected %0b", rd, value[0]));
        end
    endtask

    // A stream of mostly well-formed units; some broken, cut short or left open
    task automatic random_stream(input bit dir);
        int          units;
        int          pick;
        int          ending;
        int          len;
        bit          tail;
        logic [31:0] w;
        logic [15:0] u;
        logic [9:0]  r;
        units  = $urandom_range(1, 5);
        ending = $urandom_range(99);
        for (int i = 0; i < units; i++)
        begin
            tail = (i == units - 1) && (ending < 80);
            pick = $urandom_range(99);
            r    = 10'($urandom);
            if (dir == DIR_16_TO_32)
            begin
                len = 2;
                u   = 16'($urandom);
                if (u >= SURR_HIGH_FIRST && u <= SURR_LAST)
                    u = u ^ 16'h8000;
                if (pick < 3)
                    w = 32'h0000;
                else if (pick < 6)
                    w = 32'hFFFF;
                else if (pick < 65)
                    w = {16'b0, u};
                else if (pick < 90)
                begin
                    w   = {SURR_HIGH_FIRST | {6'b0, r},
                           SURR_LOW_FIRST | {6'b0, 10'($urandom)}};
                    len = 4;
                end
                else if (pick < 93)
                    w = {16'b0, SURR_LOW_FIRST | {6'b0, r}};
                else if (pick < 96)
                begin
                    w   = {SURR_HIGH_FIRST | {6'b0, r}, 16'($urandom)};
                    len = 4;
                end
                else
                    w = {16'b0, 16'($urandom)};
            end
            else
            begin
                len = 4;
                if (pick < 45)
                begin
                    w = $urandom_range(0, 32'hFFFF);
                    if (w >= SURR_HIGH_FIRST && w <= SURR_LAST)
                        w = w ^ 32'h8000;
                end
                else if (pick < 80)
                    w = $urandom_range(32'h10000, CP_MAX);
                else if (pick < 83)
                    w = CP_MAX;
                else if (pick < 85)
                    w = BMP_END;
                else if (pick < 90)
                    w = $urandom_range(SURR_HIGH_FIRST, SURR_LAST);
                else if (pick < 95)
                    w = $urandom_range(32'h110000, 32'hFFFFFFFF);
                else
                    w = $urandom;
            end
            send_word(w, len, tail);
        end
        // truncated endings; the rest run on into the next stream
        if (ending >= 80 && ending < 92)
        begin
            if (dir == DIR_32_TO_16)
                send_word($urandom, $urandom_range(1, 3), 1'b1);
            else if ($urandom_range(1))
                send_word($urandom, 1, 1'b1);
            else
                send_word({16'b0, SURR_HIGH_FIRST | {6'b0, 10'($urandom)}}, 2, 1'b1);
        end
    endtask

    // Main sequence
    initial
    begin
        int          target;
        logic [31:0] w;
        sb            = new();
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_left     = 0;
        bytes_in      = 0;
        dir_writes    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: UTF-16 in
        set_register(REG_DIRECTION, {31'b0, DIR_16_TO_32});
        send_word(32'h0041, 2, 1'b0);
        send_word(32'hDBFF_DFFF, 4, 1'b1);   // highest pair, stream ends cleanly
        send_word(32'hDC00, 2, 1'b1);        // lone low surrogate
        send_word(32'hD801_D802, 4, 1'b1);   // high followed by another high
        send_word(32'h12, 1, 1'b1);          // cut off mid-unit
        send_word(32'hD800, 2, 1'b1);        // high surrogate still held at the end
        drain();

        // Directed: UTF-32 in
        set_register(REG_DIRECTION, {31'b0, DIR_32_TO_16});
        send_word(32'h0010_FFFF, 4, 1'b0);   // top of range
        send_word(32'h0000_D800, 4, 1'b1);   // surrogate value
        send_word(32'hFFFF_FFFF, 4, 1'b1);   // top bit set
        drain();

        // Random: three idle mixes, both directions in each
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 65;
                end
                1:
                begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 6;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++)
            begin
                drain();
                w    = $urandom;
                w[0] = (half == 0) ? DIR_16_TO_32 : DIR_32_TO_16;
                set_register(REG_DIRECTION, w);
                target = bytes_in + 50;
                if (ph == 2 && half == 0)
                begin
                    random_stream(w[0]);
                    hold_left = LONG_HOLD;
                end
                while (bytes_in < target)
                begin
                    random_stream(w[0]);
                    // write to an unused register mid-stream; state must survive
                    if (ph == 0 && half == 1 && bytes_in >= target - 30 &&
                        bytes_in < target - 20)
                    begin
                        drain();
                        set_register(SPARE_REG, $urandom);
                    end
                end
            end
        end
        drain();

        $display("Covered %0d input bytes and %0d output bytes (%0d flagged),",
                 bytes_in, sb.checked, sb.flagged);
        $display("%0d direction writes, idle mixes 6/65, 65/6 and none, one long output hold.",
                 dir_writes);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
